// ----- rtl/swtq_pkg.sv -----
// Shared constants and types for the sorted wakeup time queue.
// No dependencies; used by every other file of the block.
`default_nettype none
package swtq_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
  localparam int TIME_W      = 64;
  localparam int TASK_W      = 32;
  localparam int STATUS_W    = 2;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_YET = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic latch;   // capture the input transaction
    logic exec;    // update the store and load the result register
  } dp_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/swtq_if.sv -----
// Valid/ready channel interfaces for the sorted wakeup time queue.
// Depends on swtq_pkg.
`default_nettype none
interface swtq_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [swtq_pkg::TIME_W-1:0]   wake_time;
  logic [swtq_pkg::TASK_W-1:0]   task_id;
  logic [swtq_pkg::TIME_W-1:0]   now_time;

  modport source (output valid, cmd, wake_time, task_id, now_time, input ready);
  modport sink   (input valid, cmd, wake_time, task_id, now_time, output ready);
endinterface

interface swtq_out_if;
  logic                          valid;
  logic                          ready;
  logic [swtq_pkg::STATUS_W-1:0] status;
  logic [swtq_pkg::TASK_W-1:0]   woken_task;
  logic [swtq_pkg::TIME_W-1:0]   head_time;
  logic                          head_valid;

  modport source (output valid, status, woken_task, head_time, head_valid, input ready);
  modport sink   (input valid, status, woken_task, head_time, head_valid, output ready);
endinterface
`default_nettype wire

// ----- rtl/swtq_ctrl.sv -----
// Controller for the sorted wakeup time queue: sequences capture and update,
// and owns the output valid flag. Depends on swtq_pkg.
`default_nettype none
module swtq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output swtq_pkg::dp_cmd_t      cmd
);
  import swtq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.latch     = in_valid && in_ready;
    cmd.exec      = (state_r == S_EXEC) && slot_free;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_exec_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> state_r == S_EXEC && !cmd.latch)
    else $error("update issued outside the execute state");
  a_exec_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("result register not marked valid after update");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !cmd.exec)
    else $error("pending result overwritten");

endmodule
`default_nettype wire

// ----- rtl/swtq_dp.sv -----
// Datapath of the sorted wakeup time queue: input capture, sorted register store
// with a comparator per slot, occupancy count and result register. Depends on swtq_pkg.
`default_nettype none
module swtq_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire swtq_pkg::dp_cmd_t             cmd,
  input  wire logic                          in_cmd,
  input  wire logic [swtq_pkg::TIME_W-1:0]   in_wake_time,
  input  wire logic [swtq_pkg::TASK_W-1:0]   in_task_id,
  input  wire logic [swtq_pkg::TIME_W-1:0]   in_now_time,
  output logic [swtq_pkg::STATUS_W-1:0]      out_status,
  output logic [swtq_pkg::TASK_W-1:0]        out_woken_task,
  output logic [swtq_pkg::TIME_W-1:0]        out_head_time,
  output logic                               out_head_valid
);
  import swtq_pkg::*;

  localparam int N = MAX_ENTRIES;

  logic              op_r;
  logic [TIME_W-1:0] wake_r;
  logic [TASK_W-1:0] id_r;
  logic [TIME_W-1:0] now_r;

  logic [TIME_W-1:0] time_r   [N];
  logic [TASK_W-1:0] task_r   [N];
  logic [TIME_W-1:0] time_nxt [N];
  logic [TASK_W-1:0] task_nxt [N];
  logic [TIME_W-1:0] ins_time [N];
  logic [TASK_W-1:0] ins_task [N];
  logic [TIME_W-1:0] del_time [N];
  logic [TASK_W-1:0] del_task [N];
  logic [N-1:0]      le;
  logic [OCC_W-1:0]  occ_r, occ_nxt;

  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [TASK_W-1:0]   woken_r, woken_nxt;
  logic [TIME_W-1:0]   head_r;
  logic                head_valid_r;
  logic                is_full, is_empty, not_due;
  logic                do_ins, do_del;

  // per-slot insert and remove candidates
  for (genvar i = 0; i < N; i++) begin : g_slot
    assign le[i] = (OCC_W'(i) < occ_r) && (time_r[i] <= wake_r);
    if (i == 0) begin : g_first
      always_comb begin
        ins_time[i] = le[i] ? time_r[i] : wake_r;
        ins_task[i] = le[i] ? task_r[i] : id_r;
      end
    end else begin : g_rest
      always_comb begin
        if (le[i]) begin
          ins_time[i] = time_r[i];
          ins_task[i] = task_r[i];
        end else if (le[i-1]) begin
          ins_time[i] = wake_r;
          ins_task[i] = id_r;
        end else begin
          ins_time[i] = time_r[i-1];
          ins_task[i] = task_r[i-1];
        end
      end
    end
    if (i == N - 1) begin : g_last
      assign del_time[i] = time_r[i];
      assign del_task[i] = task_r[i];
    end else begin : g_mid
      assign del_time[i] = time_r[i+1];
      assign del_task[i] = task_r[i+1];
    end
  end

  assign is_full  = (occ_r == OCC_W'(N));
  assign is_empty = (occ_r == '0);
  assign not_due  = time_r[0] > now_r;
  assign do_ins   = (op_r == CMD_ENQ) && !is_full;
  assign do_del   = (op_r == CMD_DEQ) && !is_empty && !not_due;

  always_comb begin
    occ_nxt    = occ_r;
    woken_nxt  = '0;
    status_nxt = ST_OK;
    for (int i = 0; i < N; i++) begin
      time_nxt[i] = time_r[i];
      task_nxt[i] = task_r[i];
    end
    if (op_r == CMD_ENQ) begin
      if (is_full) begin
        status_nxt = ST_FULL;
      end else begin
        occ_nxt = occ_r + OCC_W'(1);
        for (int i = 0; i < N; i++) begin
          time_nxt[i] = ins_time[i];
          task_nxt[i] = ins_task[i];
        end
      end
    end else begin
      if (is_empty) begin
        status_nxt = ST_EMPTY;
      end else if (not_due) begin
        status_nxt = ST_NOT_YET;
      end else begin
        occ_nxt   = occ_r - OCC_W'(1);
        woken_nxt = task_r[0];
        for (int i = 0; i < N; i++) begin
          time_nxt[i] = del_time[i];
          task_nxt[i] = del_task[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_cmd;
      wake_r <= in_wake_time;
      id_r   <= in_task_id;
      now_r  <= in_now_time;
    end
    if (cmd.exec) begin
      for (int i = 0; i < N; i++) begin
        time_r[i] <= time_nxt[i];
        task_r[i] <= task_nxt[i];
      end
      status_r     <= status_nxt;
      woken_r      <= woken_nxt;
      head_valid_r <= (occ_nxt != '0);
      head_r       <= (occ_nxt != '0) ? time_nxt[0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (cmd.exec) begin
      occ_r <= occ_nxt;
    end
  end

  assign out_status     = status_r;
  assign out_woken_task = woken_r;
  assign out_head_time  = head_r;
  assign out_head_valid = head_valid_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(N))
    else $error("occupancy above capacity");
  a_occ_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.exec |=> $stable(occ_r))
    else $error("occupancy changed without an update");
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && do_ins |=> occ_r == $past(occ_r) + OCC_W'(1))
    else $error("insert did not grow occupancy");
  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && do_del |=> occ_r == $past(occ_r) - OCC_W'(1))
    else $error("removal did not shrink occupancy");
  a_head_flag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> head_valid_r == (occ_r != '0))
    else $error("head flag disagrees with occupancy");

endmodule
`default_nettype wire

// ----- rtl/sorted_wakeup_time_queue_unit.sv -----
// Top level of the sorted wakeup time queue: controller plus datapath.
// Depends on swtq_pkg, swtq_if, swtq_ctrl and swtq_dp.
//
// Holds up to MAX_ENTRIES (wake time, task id) pairs kept in ascending time
// order in registers, with first-in-first-out order among equal times. Each
// request is first captured and then applied to the store; on an enqueue every
// slot compares its time against the new time at once and the later entries
// shift by one place. A new request is taken only once the previous one has
// updated the store; an unclaimed result holds the update step until the
// result register frees. No clearing pass is needed after reset.
`default_nettype none
module sorted_wakeup_time_queue_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  swtq_in_if.sink   in_ch,
  swtq_out_if.source out_ch
);
  import swtq_pkg::*;

  dp_cmd_t cmd;

  swtq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  swtq_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_cmd         (in_ch.cmd),
    .in_wake_time   (in_ch.wake_time),
    .in_task_id     (in_ch.task_id),
    .in_now_time    (in_ch.now_time),
    .out_status     (out_ch.status),
    .out_woken_task (out_ch.woken_task),
    .out_head_time  (out_ch.head_time),
    .out_head_valid (out_ch.head_valid)
  );

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for sorted_wakeup_time_queue_unit: directed and random
// enqueue/dequeue traffic with random stalls, scored against a sorted-queue predictor.
// Depends on swtq_pkg, swtq_if and the RTL of the block.
module tb;
  import swtq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1950;
  localparam int QUIET_FROM = 1700;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TASK_W-1:0]   woken_task;
    logic [TIME_W-1:0]   head_time;
    logic                head_valid;
  } wakeup_result_t;

  class wakeup_queue_checker;
    logic [TIME_W-1:0] slot_times[$];
    logic [TASK_W-1:0] slot_tasks[$];
    wakeup_result_t    awaited_results[$];
    int                mismatches;

    function new();
      mismatches = 0;
    endfunction

    function bit has_head();
      return slot_times.size() > 0;
    endfunction

    function logic [TIME_W-1:0] head_time();
      return (slot_times.size() > 0) ? slot_times[0] : '0;
    endfunction

    function int awaiting();
      return awaited_results.size();
    endfunction

    // Predict the result of one accepted transaction and update the sorted store.
    function void note_request(logic cmd, logic [TIME_W-1:0] wake, logic [TASK_W-1:0] id,
                               logic [TIME_W-1:0] now);
      wakeup_result_t r;
      int pos;
      r = '0;
      r.status = ST_OK;
      if (cmd == CMD_ENQ) begin
        if (slot_times.size() >= MAX_ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < slot_times.size() && slot_times[pos] <= wake) pos++;
          slot_times.insert(pos, wake);
          slot_tasks.insert(pos, id);
        end
      end else if (slot_times.size() == 0) begin
        r.status = ST_EMPTY;
      end else if (slot_times[0] > now) begin
        r.status = ST_NOT_YET;
      end else begin
        r.woken_task = slot_tasks.pop_front();
        void'(slot_times.pop_front());
      end
      r.head_valid = slot_times.size() > 0;
      r.head_time = head_time();
      awaited_results.push_back(r);
    endfunction

    function void report(string what, wakeup_result_t want, wakeup_result_t got);
      if (mismatches < 10)
        $display("%0t %s: exp st=%0d task=%h head=%h hv=%b got st=%0d task=%h head=%h hv=%b",
                 $time, what, want.status, want.woken_task, want.head_time, want.head_valid,
                 got.status, got.woken_task, got.head_time, got.head_valid);
      mismatches++;
    endfunction

    function void check_result(wakeup_result_t got);
      wakeup_result_t want;
      if (awaited_results.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status || got.woken_task !== want.woken_task ||
          got.head_time !== want.head_time || got.head_valid !== want.head_valid)
        report("mismatch", want, got);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycle_count = 0;
  bit   quiet = 1'b0;
  int   gap_pct = 20;
  logic [TIME_W-1:0] epoch = '0;

  wakeup_queue_checker sb;

  swtq_in_if  in_ch();
  swtq_out_if out_ch();

  sorted_wakeup_time_queue_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.status, out_ch.woken_task, out_ch.head_time, out_ch.head_valid});
  end

  // result-side back-pressure in random bursts
  initial begin
    int hold;
    int window;
    int stall_pct;
    hold = 0;
    window = 0;
    stall_pct = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (window == 0) begin
        window = 64;
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 30;
        endcase
      end
      window--;
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        hold = $urandom_range(1, 11) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send(logic cmd, logic [TIME_W-1:0] wake, logic [TASK_W-1:0] id,
                      logic [TIME_W-1:0] now);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.wake_time <= wake;
    in_ch.task_id   <= id;
    in_ch.now_time  <= now;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(cmd, wake, id, now);
  endtask

  function automatic logic [TIME_W-1:0] pick_wake();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return epoch + TIME_W'($urandom_range(0, 24));
      6, 7: return {$urandom, $urandom};
      8: return '1 - TIME_W'($urandom_range(0, 3));
      default: return TIME_W'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_now();
    logic [TIME_W-1:0] h;
    h = sb.head_time();
    if (!sb.has_head())
      return ($urandom_range(0, 1) != 0) ? {$urandom, $urandom} : epoch;
    case ($urandom_range(0, 9))
      0, 1, 2: return h - TIME_W'($urandom_range(1, 3));
      3, 4: return h;
      5, 6: return h + TIME_W'($urandom_range(1, 30));
      7: return {$urandom, $urandom};
      8: return '0;
      default: return '1;
    endcase
  endfunction

  initial begin
    int enq_pct;
    logic cmd;
    sb = new();
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_ENQ;
    in_ch.wake_time = '0;
    in_ch.task_id = '0;
    in_ch.now_time = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty, due-exactly-now, not yet due, equal-time order, fill to full
    send(CMD_DEQ, '0, '0, '1);
    send(CMD_ENQ, 64'd5, 32'h0000_00a1, '0);
    send(CMD_ENQ, 64'd5, 32'h0000_00b2, '1);
    send(CMD_ENQ, '0, '0, '0);
    send(CMD_ENQ, '1, '1, '0);
    send(CMD_DEQ, '1, '1, '0);
    send(CMD_DEQ, '0, '0, 64'd4);
    send(CMD_DEQ, '0, '0, 64'd5);
    send(CMD_DEQ, '0, '0, 64'd5);
    send(CMD_DEQ, '0, '0, '1 - 64'd1);
    for (int k = 0; k < MAX_ENTRIES - 1; k++)
      send(CMD_ENQ, TIME_W'(1000 - k * 10), TASK_W'(32'h100 + k), '0);
    send(CMD_ENQ, 64'd7, 32'hdead_beef, '0);

    enq_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 2))
          0: enq_pct = 25;
          1: enq_pct = 55;
          default: enq_pct = 80;
        endcase
        case ($urandom_range(0, 3))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 35;
        endcase
        case ($urandom_range(0, 3))
          0: epoch = '0;
          1: epoch = '1 - TIME_W'(20);
          default: epoch = {$urandom, $urandom};
        endcase
      end
      quiet = (n >= QUIET_FROM);
      cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
      send(cmd, pick_wake(), $urandom, pick_now());
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (sb.awaiting() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaiting() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end
endmodule
